// File: rtl/sd_spi_init_and_block_read_defines.svh
// Assertion macros used by the SD SPI host sequencer RTL.
`ifndef SD_SPI_INIT_AND_BLOCK_READ_DEFINES_SVH
`define SD_SPI_INIT_AND_BLOCK_READ_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define SDSPI_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define SDSPI_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

// File: rtl/sdspi_pkg.sv
// Package with types, codes and constants of the SD SPI host sequencer.
package sdspi_pkg;

   localparam int unsigned BLOCK_BYTES = 512;
   localparam int unsigned BLOCK_SHIFT = $clog2(BLOCK_BYTES);
   localparam int unsigned BC_W = 12;

   typedef logic [BC_W-1:0] bc_type;

   localparam logic [1:0] CMD_INIT = 2'd0;
   localparam logic [1:0] CMD_READ = 2'd1;
   localparam logic [1:0] CMD_RX   = 2'd2;
   localparam logic [1:0] CMD_TICK = 2'd3;

   localparam logic [2:0] REG_RESP_ATT  = 3'd0;
   localparam logic [2:0] REG_READY_TO  = 3'd1;
   localparam logic [2:0] REG_INIT_TO   = 3'd2;
   localparam logic [2:0] REG_TOKEN_TO  = 3'd3;
   localparam logic [2:0] REG_IDLE_RETR = 3'd4;
   localparam logic [2:0] REG_DUMMY     = 3'd5;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_ERR   = 2'd1;
   localparam logic [1:0] STAT_NRDY  = 2'd2;
   localparam logic [1:0] STAT_PARAM = 2'd3;

   typedef enum logic [4:0] {
      PH_IDLE, PH_DUMMY, PH_CMD0, PH_CMD8, PH_R7, PH_HCS, PH_CMD58, PH_OCR,
      PH_PROBE, PH_POLL, PH_CMD16, PH_INIT_END, PH_RDCMD, PH_TOKEN, PH_DATA,
      PH_CRC, PH_STOP, PH_READ_END
   } phase_type;

   typedef enum logic [2:0] {
      ST_DESEL, ST_READY, ST_BYTES, ST_STUFF, ST_RESP, ST_FAIL
   } stage_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  rx_byte;
      logic        drive;
      logic [31:0] sector;
      logic [15:0] block_count;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_valid;
      logic       card_selected;
      logic [7:0] data_byte;
      logic       data_valid;
      logic       done_res;
      logic [1:0] status;
      logic [3:0] card_kind;
      logic       not_initialized;
   } rsp_type;

   typedef struct packed {
      logic [7:0] response_attempts;
      logic [7:0] ready_timeout_ticks;
      logic [7:0] init_timeout_ticks;
      logic [7:0] token_timeout_ticks;
      logic [7:0] idle_retries;
      logic [7:0] dummy_bytes;
   } cfg_type;

   // Complete sequencer state, one register set.
   typedef struct packed {
      phase_type   phase;
      stage_type   stage;
      logic [7:0]  init_tmo;
      logic [7:0]  wait_timer;
      logic [3:0]  card_type;
      logic        uninit;
      logic [7:0]  retry_counter;
      bc_type      byte_counter;
      logic [31:0] ocr;
      logic [31:0] address;
      logic [15:0] blocks_left;
      logic [5:0]  current_cmd;
      logic [2:0]  cmd_idx;
      logic [7:0]  attempts;
      logic        acmd_pending;
      logic [3:0]  new_type;
      logic        poll_acmd;
      logic        multi;
      logic [31:0] cmd_arg;
      logic        acmd_hcs;
      logic [7:0]  txb;
      logic        txv;
      logic        csel;
   } seq_type;

endpackage

// File: rtl/sd_spi_init_and_block_read.sv
// Top level of the SPI-mode SD card host sequencer.
//  channel  ports                          direction  payload
//  request  req_valid/req_stall/req_data   in         command, rx byte, read request
//  response rsp_valid/rsp_stall/rsp_data   out        next SPI byte, data, status
//  config   csr_write/csr_index/csr_data   in         six 8-bit timing and count registers
// For every item the sequencer state advances as the item is taken
// and its result lands in the output register on the same edge.
// A new item is accepted every cycle while the output register is empty or being
// drained; a stall on the response side holds the result and stops intake.
// Reset is synchronous and needs no clearing pass.
module sd_spi_init_and_block_read (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sdspi_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sdspi_pkg::rsp_type  rsp_data,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [7:0]          csr_data
);

   sdspi_pkg::cfg_type cfg;
   sdspi_pkg::rsp_type rsp_next;
   sdspi_pkg::rsp_type rsp_ff;
   logic               valid_ff;
   logic               step;

   assign req_stall = valid_ff && rsp_stall;
   assign step = req_valid && !req_stall;

   sdspi_cfg u_cfg (
      .clock(clock), .reset(reset), .csr_write(csr_write),
      .csr_index(csr_index), .csr_data(csr_data), .cfg(cfg)
   );

   sdspi_seq u_seq (
      .clock(clock), .reset(reset), .step(step), .req(req_data),
      .cfg(cfg), .rsp(rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= step;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// File: rtl/sdspi_cfg.sv
// Configuration register file of the SD SPI host sequencer.
module sdspi_cfg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [2:0]            csr_index,
   input  logic [7:0]            csr_data,
   output sdspi_pkg::cfg_type    cfg
);

   sdspi_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            sdspi_pkg::REG_RESP_ATT:  cfg_in.response_attempts   = csr_data;
            sdspi_pkg::REG_READY_TO:  cfg_in.ready_timeout_ticks = csr_data;
            sdspi_pkg::REG_INIT_TO:   cfg_in.init_timeout_ticks  = csr_data;
            sdspi_pkg::REG_TOKEN_TO:  cfg_in.token_timeout_ticks = csr_data;
            sdspi_pkg::REG_IDLE_RETR: cfg_in.idle_retries        = csr_data;
            sdspi_pkg::REG_DUMMY:     cfg_in.dummy_bytes         = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{8'd10, 8'd50, 8'd100, 8'd20, 8'd100, 8'd100};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/sdspi_seq.sv
// Sequencer state register and the next-state logic for one item.
`include "sd_spi_init_and_block_read_defines.svh"

module sdspi_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  sdspi_pkg::req_type    req,
   input  sdspi_pkg::cfg_type    cfg,
   output sdspi_pkg::rsp_type    rsp
);

   sdspi_pkg::seq_type s_ff, s_in;
   logic [7:0] o_data;
   logic       o_dv;
   logic       o_done;
   logic [1:0] o_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff <= '{phase: sdspi_pkg::PH_IDLE, stage: sdspi_pkg::ST_DESEL,
                   uninit: 1'b1, txb: 8'hFF, default: '0};
      end else if (step) begin
         s_ff <= s_in;
      end
   end

   always_comb begin
      sdspi_pkg::seq_type n;
      logic [7:0] rx;
      logic       have_resp;
      logic [7:0] r;
      logic [7:0] cb;
      logic       go58, go16, gohcs, gopoll, gofin, gotok, goafter, gorfin;
      logic       start_valid;
      logic [5:0] sc_cmd;
      logic [31:0] sc_arg;
      logic       sc_acmd;
      logic [31:0] ocr_n;
      sdspi_pkg::bc_type bc1;
      n = s_ff;
      rx = req.rx_byte;
      have_resp = 1'b0;
      r = 8'hFF;
      cb = 8'h01;
      go58 = 1'b0; go16 = 1'b0; gohcs = 1'b0; gopoll = 1'b0; gofin = 1'b0;
      gotok = 1'b0; goafter = 1'b0; gorfin = 1'b0;
      start_valid = 1'b0; sc_cmd = '0; sc_arg = '0; sc_acmd = 1'b0;
      ocr_n = {s_ff.ocr[23:0], rx};
      bc1 = s_ff.byte_counter + sdspi_pkg::bc_type'(1);
      o_data = 8'h00; o_dv = 1'b0; o_done = 1'b0; o_status = sdspi_pkg::STAT_OK;

      // Command frame byte for the current index.
      case (s_ff.cmd_idx)
         3'd1: cb = s_ff.cmd_arg[31:24];
         3'd2: cb = s_ff.cmd_arg[23:16];
         3'd3: cb = s_ff.cmd_arg[15:8];
         3'd4: cb = s_ff.cmd_arg[7:0];
         default: begin
            if (s_ff.current_cmd == 6'd0) cb = 8'h95;
            else if (s_ff.current_cmd == 6'd8) cb = 8'h87;
            else cb = 8'h01;
         end
      endcase

      case (req.command)
         sdspi_pkg::CMD_INIT: begin
            if (s_ff.phase == sdspi_pkg::PH_IDLE) begin
               n.init_tmo = '0;
               n.wait_timer = '0;
               n.phase = sdspi_pkg::PH_DUMMY;
               n.byte_counter = sdspi_pkg::bc_type'(cfg.dummy_bytes) +
                                sdspi_pkg::bc_type'(1);
               n.txb = 8'hFF; n.txv = 1'b1; n.csel = 1'b0;
            end
         end
         sdspi_pkg::CMD_READ: begin
            if (s_ff.phase == sdspi_pkg::PH_IDLE) begin
               if (req.drive || req.block_count == 16'd0) begin
                  o_done = 1'b1; o_status = sdspi_pkg::STAT_PARAM;
               end else if (s_ff.uninit) begin
                  o_done = 1'b1; o_status = sdspi_pkg::STAT_NRDY;
               end else begin
                  n.address = s_ff.card_type[3] ? req.sector :
                              (req.sector << sdspi_pkg::BLOCK_SHIFT);
                  n.blocks_left = req.block_count;
                  n.multi = (req.block_count > 16'd1);
                  n.phase = sdspi_pkg::PH_RDCMD;
                  start_valid = 1'b1;
                  sc_cmd = (req.block_count > 16'd1) ? 6'd18 : 6'd17;
                  sc_arg = n.address;
               end
            end
         end
         sdspi_pkg::CMD_TICK: begin
            if (s_ff.init_tmo != 8'd0) n.init_tmo = s_ff.init_tmo - 8'd1;
            if (s_ff.wait_timer != 8'd0) n.wait_timer = s_ff.wait_timer - 8'd1;
         end
         default: begin
            if (s_ff.phase != sdspi_pkg::PH_IDLE && s_ff.txv) begin
               case (s_ff.phase)
                  sdspi_pkg::PH_DUMMY: begin
                     n.byte_counter = (s_ff.byte_counter > 1) ?
                                      s_ff.byte_counter - sdspi_pkg::bc_type'(1) : '0;
                     if (s_ff.byte_counter > 1) begin
                        n.txb = 8'hFF; n.txv = 1'b1; n.csel = 1'b0;
                     end else begin
                        n.phase = sdspi_pkg::PH_CMD0;
                        n.retry_counter = cfg.idle_retries;
                        n.new_type = '0;
                        start_valid = 1'b1; sc_cmd = 6'd0; sc_arg = '0;
                     end
                  end
                  sdspi_pkg::PH_R7, sdspi_pkg::PH_OCR: begin
                     n.ocr = ocr_n;
                     n.byte_counter = bc1;
                     if (bc1 < sdspi_pkg::bc_type'(4)) begin
                        n.txb = 8'hFF; n.txv = 1'b1; n.csel = 1'b1;
                     end else if (s_ff.phase == sdspi_pkg::PH_OCR) begin
                        n.new_type = ocr_n[30] ? 4'd12 : 4'd4;
                        go16 = 1'b1;
                     end else if (ocr_n[15:0] == 16'h01AA) begin
                        gohcs = 1'b1;
                     end else begin
                        n.new_type = '0;
                        go16 = 1'b1;
                     end
                  end
                  sdspi_pkg::PH_INIT_END: begin
                     n.card_type = s_ff.new_type;
                     n.uninit = (s_ff.new_type == 4'd0);
                     o_done = 1'b1;
                     o_status = (s_ff.new_type == 4'd0) ? sdspi_pkg::STAT_NRDY
                                                        : sdspi_pkg::STAT_OK;
                     n.txb = 8'hFF; n.txv = 1'b0; n.csel = 1'b0;
                     n.phase = sdspi_pkg::PH_IDLE;
                  end
                  sdspi_pkg::PH_TOKEN: begin
                     if (rx == 8'hFF && s_ff.wait_timer != 8'd0) begin
                        n.txb = 8'hFF; n.txv = 1'b1; n.csel = 1'b1;
                     end else if (rx == 8'hFE) begin
                        n.phase = sdspi_pkg::PH_DATA; n.byte_counter = '0;
                        n.txb = 8'hFF; n.txv = 1'b1; n.csel = 1'b1;
                     end else begin
                        goafter = 1'b1;
                     end
                  end
                  sdspi_pkg::PH_DATA: begin
                     o_data = rx; o_dv = 1'b1;
                     n.byte_counter = bc1;
                     if (bc1 >= sdspi_pkg::bc_type'(sdspi_pkg::BLOCK_BYTES)) begin
                        n.phase = sdspi_pkg::PH_CRC; n.byte_counter = '0;
                     end
                     n.txb = 8'hFF; n.txv = 1'b1; n.csel = 1'b1;
                  end
                  sdspi_pkg::PH_CRC: begin
                     n.byte_counter = bc1;
                     if (bc1 < sdspi_pkg::bc_type'(2)) begin
                        n.txb = 8'hFF; n.txv = 1'b1; n.csel = 1'b1;
                     end else begin
                        n.blocks_left = s_ff.blocks_left - 16'd1;
                        if (s_ff.blocks_left != 16'd1) gotok = 1'b1;
                        else goafter = 1'b1;
                     end
                  end
                  sdspi_pkg::PH_READ_END: begin
                     o_done = 1'b1;
                     o_status = (s_ff.blocks_left != 16'd0) ? sdspi_pkg::STAT_ERR
                                                            : sdspi_pkg::STAT_OK;
                     n.txb = 8'hFF; n.txv = 1'b0; n.csel = 1'b0;
                     n.phase = sdspi_pkg::PH_IDLE;
                  end
                  default: begin
                     // Command exchange engine.
                     unique case (s_ff.stage)
                        sdspi_pkg::ST_DESEL: begin
                           n.stage = sdspi_pkg::ST_READY;
                           n.wait_timer = cfg.ready_timeout_ticks;
                           n.txb = 8'hFF; n.txv = 1'b1; n.csel = 1'b1;
                        end
                        sdspi_pkg::ST_READY: begin
                           if (rx == 8'hFF) begin
                              n.stage = sdspi_pkg::ST_BYTES; n.cmd_idx = 3'd1;
                              n.txb = {2'b01, s_ff.current_cmd};
                              n.txv = 1'b1; n.csel = 1'b1;
                           end else if (s_ff.wait_timer == 8'd0) begin
                              n.stage = sdspi_pkg::ST_FAIL;
                              n.txb = 8'hFF; n.txv = 1'b1; n.csel = 1'b0;
                           end else begin
                              n.txb = 8'hFF; n.txv = 1'b1; n.csel = 1'b1;
                           end
                        end
                        sdspi_pkg::ST_BYTES: begin
                           n.txv = 1'b1; n.csel = 1'b1;
                           if (s_ff.cmd_idx < 3'd6) begin
                              n.txb = cb; n.cmd_idx = s_ff.cmd_idx + 3'd1;
                           end else begin
                              n.attempts = cfg.response_attempts;
                              n.stage = (s_ff.current_cmd == 6'd12) ?
                                        sdspi_pkg::ST_STUFF : sdspi_pkg::ST_RESP;
                              n.txb = 8'hFF;
                           end
                        end
                        sdspi_pkg::ST_STUFF: begin
                           n.stage = sdspi_pkg::ST_RESP;
                           n.txb = 8'hFF; n.txv = 1'b1; n.csel = 1'b1;
                        end
                        sdspi_pkg::ST_RESP: begin
                           if (rx[7] && s_ff.attempts > 8'd1) begin
                              n.attempts = s_ff.attempts - 8'd1;
                              n.txb = 8'hFF; n.txv = 1'b1; n.csel = 1'b1;
                           end else begin
                              have_resp = 1'b1; r = rx;
                           end
                        end
                        default: begin
                           have_resp = 1'b1; r = 8'hFF;
                        end
                     endcase
                  end
               endcase
            end
         end
      endcase

      // Response handling.
      if (have_resp) begin
         n.acmd_pending = 1'b0;
         if (s_ff.current_cmd == 6'd55 && s_ff.acmd_pending && r <= 8'd1) begin
            start_valid = 1'b1; sc_cmd = 6'd41;
            sc_arg = {1'b0, s_ff.acmd_hcs, 30'd0};
         end else begin
            case (s_ff.phase)
               sdspi_pkg::PH_CMD0: begin
                  if (r == 8'd1) begin
                     n.init_tmo = cfg.init_timeout_ticks;
                     n.phase = sdspi_pkg::PH_CMD8;
                     start_valid = 1'b1; sc_cmd = 6'd8; sc_arg = 32'h1AA;
                  end else if (s_ff.retry_counter > 8'd1) begin
                     n.retry_counter = s_ff.retry_counter - 8'd1;
                     start_valid = 1'b1; sc_cmd = 6'd0;
                  end else begin
                     n.new_type = '0; gofin = 1'b1;
                  end
               end
               sdspi_pkg::PH_CMD8: begin
                  if (r == 8'd1) begin
                     n.phase = sdspi_pkg::PH_R7; n.byte_counter = '0; n.ocr = '0;
                     n.txb = 8'hFF; n.txv = 1'b1; n.csel = 1'b1;
                  end else begin
                     n.phase = sdspi_pkg::PH_PROBE;
                     start_valid = 1'b1; sc_acmd = 1'b1;
                  end
               end
               sdspi_pkg::PH_HCS: begin
                  if (r == 8'd0) go58 = 1'b1; else gohcs = 1'b1;
               end
               sdspi_pkg::PH_CMD58: begin
                  if (r == 8'd0) begin
                     n.phase = sdspi_pkg::PH_OCR; n.byte_counter = '0; n.ocr = '0;
                     n.txb = 8'hFF; n.txv = 1'b1; n.csel = 1'b1;
                  end else go58 = 1'b1;
               end
               sdspi_pkg::PH_PROBE: begin
                  n.new_type = (r <= 8'd1) ? 4'd2 : 4'd1;
                  n.poll_acmd = (r <= 8'd1);
                  gopoll = 1'b1;
               end
               sdspi_pkg::PH_POLL: begin
                  if (r != 8'd0) gopoll = 1'b1; else go16 = 1'b1;
               end
               sdspi_pkg::PH_CMD16: begin
                  // A zero response while still in this phase also ends init.
                  go16 = 1'b1;
               end
               sdspi_pkg::PH_RDCMD: begin
                  if (r == 8'd0) gotok = 1'b1; else gorfin = 1'b1;
               end
               default: gorfin = 1'b1;
            endcase
         end
      end

      // Chained init and read steps; several may fall through to a later step.
      if (gopoll) begin
         if (s_ff.init_tmo == 8'd0) go16 = 1'b1;
         else begin
            n.phase = sdspi_pkg::PH_POLL; start_valid = 1'b1;
            if (n.poll_acmd) sc_acmd = 1'b1; else sc_cmd = 6'd1;
         end
      end
      if (gohcs) begin
         if (s_ff.init_tmo != 8'd0) begin
            n.phase = sdspi_pkg::PH_HCS; start_valid = 1'b1; sc_acmd = 1'b1;
            sc_arg = 32'h4000_0000;
         end else go58 = 1'b1;
      end
      if (go58) begin
         if (s_ff.init_tmo != 8'd0) begin
            n.phase = sdspi_pkg::PH_CMD58; start_valid = 1'b1; sc_cmd = 6'd58;
         end else go16 = 1'b1;
      end
      if (go16) begin
         if (n.new_type != 4'd12 && s_ff.init_tmo != 8'd0 &&
             !(s_ff.phase == sdspi_pkg::PH_CMD16 && have_resp && r == 8'd0)) begin
            n.phase = sdspi_pkg::PH_CMD16; start_valid = 1'b1; sc_cmd = 6'd16;
            sc_arg = 32'(sdspi_pkg::BLOCK_BYTES);
         end else begin
            if (s_ff.init_tmo == 8'd0) n.new_type = '0;
            gofin = 1'b1;
         end
      end
      if (gofin) begin
         n.phase = sdspi_pkg::PH_INIT_END;
         n.txb = 8'hFF; n.txv = 1'b1; n.csel = 1'b0;
      end
      if (gotok) begin
         n.wait_timer = cfg.token_timeout_ticks;
         n.phase = sdspi_pkg::PH_TOKEN;
         n.txb = 8'hFF; n.txv = 1'b1; n.csel = 1'b1;
      end
      if (goafter) begin
         if (s_ff.multi) begin
            n.phase = sdspi_pkg::PH_STOP; start_valid = 1'b1; sc_cmd = 6'd12;
         end else gorfin = 1'b1;
      end
      if (gorfin) begin
         n.phase = sdspi_pkg::PH_READ_END;
         n.txb = 8'hFF; n.txv = 1'b1; n.csel = 1'b0;
      end

      // Launch a command; an application command goes out as CMD55 first.
      if (start_valid) begin
         if (sc_acmd) begin
            n.acmd_pending = 1'b1;
            n.acmd_hcs = sc_arg[30];
            n.current_cmd = 6'd55;
            n.cmd_arg = '0;
         end else begin
            n.current_cmd = sc_cmd;
            n.cmd_arg = sc_arg;
         end
         n.stage = sdspi_pkg::ST_DESEL;
         n.txb = 8'hFF; n.txv = 1'b1; n.csel = 1'b0;
      end
      s_in = n;
   end

   assign rsp.tx_byte         = s_in.txb;
   assign rsp.tx_valid        = s_in.txv;
   assign rsp.card_selected   = s_in.csel;
   assign rsp.data_byte       = o_data;
   assign rsp.data_valid      = o_dv;
   assign rsp.done_res        = o_done;
   assign rsp.status          = o_status;
   assign rsp.card_kind       = s_in.card_type;
   assign rsp.not_initialized = s_in.uninit;

   `SDSPI_ASSERT_IMPL(a_idle_quiet, clock, reset,
      s_ff.phase == sdspi_pkg::PH_IDLE, !s_ff.txv && !s_ff.csel,
      "idle sequencer requests an exchange")
   `SDSPI_ASSERT_IMPL(a_data_in_read, clock, reset,
      step && o_dv, s_ff.phase == sdspi_pkg::PH_DATA,
      "data byte outside a data phase")
   `SDSPI_ASSERT_NEXT(a_done_to_idle, clock, reset,
      step && o_done, s_ff.phase == sdspi_pkg::PH_IDLE,
      "completion without return to idle")
   `SDSPI_ASSERT_IMPL(a_count_range, clock, reset,
      s_ff.phase == sdspi_pkg::PH_DATA,
      s_ff.byte_counter < sdspi_pkg::bc_type'(sdspi_pkg::BLOCK_BYTES),
      "block byte count out of range")

endmodule

// File: test/sd_spi_read_checker.sv
`timescale 1ns / 100ps
// Checker that mirrors the SD SPI host sequencer and compares every response item.
module sd_spi_read_checker
   import sdspi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  rsp_type    rsp_data,
   input  logic       csr_write,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data,
   output int         mismatches,
   output int         outstanding
);

   localparam logic [5:0] SD_GO_IDLE   = 6'd0;
   localparam logic [5:0] SD_SEND_OP   = 6'd1;
   localparam logic [5:0] SD_SEND_IF   = 6'd8;
   localparam logic [5:0] SD_STOP      = 6'd12;
   localparam logic [5:0] SD_SET_BLEN  = 6'd16;
   localparam logic [5:0] SD_RD_SINGLE = 6'd17;
   localparam logic [5:0] SD_RD_MULTI  = 6'd18;
   localparam logic [5:0] SD_APP_OP    = 6'd41;
   localparam logic [5:0] SD_APP_CMD   = 6'd55;
   localparam logic [5:0] SD_READ_OCR  = 6'd58;

   logic [7:0]  c_resp_att, c_ready_to, c_init_to, c_token_to, c_idle_retr, c_dummy;
   phase_type   ph;
   stage_type   stg;
   logic [7:0]  init_tmr, wait_tmr, retries, attempts, txb, o_data;
   logic [3:0]  kind, new_kind;
   logic [15:0] bcnt, blocks_left;
   logic [31:0] ocr, addr, arg, acmd_arg;
   logic [5:0]  cur_cmd;
   logic [2:0]  frame_idx;
   logic        not_init, acmd_pend, poll_acmd, multi, txv, csel, o_dv, o_done;
   logic [1:0]  o_status;
   rsp_type     expected_q[$];
   rsp_type     want;

   function automatic void xfer(input logic [7:0] b, input logic sel);
      txb = b;
      txv = 1'b1;
      csel = sel;
   endfunction

   function automatic void stop_io();
      txb = 8'hFF;
      txv = 1'b0;
      csel = 1'b0;
   endfunction

   function automatic void start_cmd(input logic [5:0] c, input logic [31:0] a);
      cur_cmd = c;
      arg = a;
      stg = ST_DESEL;
      xfer(8'hFF, 1'b0);
   endfunction

   function automatic void start_acmd(input logic [31:0] a);
      acmd_pend = 1'b1;
      acmd_arg = a;
      start_cmd(SD_APP_CMD, 32'd0);
   endfunction

   function automatic logic [7:0] cmd_byte(input logic [2:0] i);
      if (i == 0) return {2'b01, cur_cmd};
      if (i < 5) return 8'(arg >> (8 * (4 - i)));
      if (cur_cmd == SD_GO_IDLE) return 8'h95;
      if (cur_cmd == SD_SEND_IF) return 8'h87;
      return 8'h01;
   endfunction

   // Advances one command exchange; returns 1 once the response byte is known.
   function automatic bit cmd_rx(input logic [7:0] rx, output logic [7:0] r);
      r = 8'hFF;
      case (stg)
         ST_DESEL: begin
            stg = ST_READY;
            wait_tmr = c_ready_to;
            xfer(8'hFF, 1'b1);
            return 1'b0;
         end
         ST_READY: begin
            if (rx == 8'hFF) begin
               stg = ST_BYTES;
               frame_idx = 3'd1;
               xfer(cmd_byte(3'd0), 1'b1);
            end else if (wait_tmr == 0) begin
               stg = ST_FAIL;
               xfer(8'hFF, 1'b0);
            end else begin
               xfer(8'hFF, 1'b1);
            end
            return 1'b0;
         end
         ST_BYTES: begin
            if (frame_idx < 6) begin
               xfer(cmd_byte(frame_idx), 1'b1);
               frame_idx++;
               return 1'b0;
            end
            attempts = c_resp_att;
            stg = (cur_cmd == SD_STOP) ? ST_STUFF : ST_RESP;
            xfer(8'hFF, 1'b1);
            return 1'b0;
         end
         ST_STUFF: begin
            stg = ST_RESP;
            xfer(8'hFF, 1'b1);
            return 1'b0;
         end
         ST_RESP: begin
            if (rx[7] && attempts > 1) begin
               attempts--;
               xfer(8'hFF, 1'b1);
               return 1'b0;
            end
            r = rx;
            return 1'b1;
         end
         default: return 1'b1;
      endcase
   endfunction

   function automatic void finish_init();
      ph = PH_INIT_END;
      xfer(8'hFF, 1'b0);
   endfunction

   function automatic void enter_cmd16();
      if (new_kind != 4'd12 && init_tmr != 0) begin
         ph = PH_CMD16;
         start_cmd(SD_SET_BLEN, BLOCK_BYTES);
         return;
      end
      if (init_tmr == 0) new_kind = 4'd0;
      finish_init();
   endfunction

   function automatic void enter_cmd58();
      if (init_tmr != 0) begin
         ph = PH_CMD58;
         start_cmd(SD_READ_OCR, 32'd0);
      end else begin
         enter_cmd16();
      end
   endfunction

   function automatic void hcs_iter();
      if (init_tmr != 0) begin
         ph = PH_HCS;
         start_acmd(32'h4000_0000);
      end else begin
         enter_cmd58();
      end
   endfunction

   function automatic void poll_iter();
      if (init_tmr == 0) begin
         enter_cmd16();
         return;
      end
      ph = PH_POLL;
      if (poll_acmd) start_acmd(32'd0);
      else start_cmd(SD_SEND_OP, 32'd0);
   endfunction

   function automatic void read_finish();
      ph = PH_READ_END;
      xfer(8'hFF, 1'b0);
   endfunction

   function automatic void token_start();
      wait_tmr = c_token_to;
      ph = PH_TOKEN;
      xfer(8'hFF, 1'b1);
   endfunction

   function automatic void after_blocks();
      if (multi) begin
         ph = PH_STOP;
         start_cmd(SD_STOP, 32'd0);
      end else begin
         read_finish();
      end
   endfunction

   function automatic void read_four(input phase_type p);
      ph = p;
      bcnt = 16'd0;
      ocr = 32'd0;
      xfer(8'hFF, 1'b1);
   endfunction

   function automatic void on_resp(input logic [7:0] r);
      // A CMD55 answer above one stands in for the whole application command.
      if (cur_cmd == SD_APP_CMD && acmd_pend) begin
         acmd_pend = 1'b0;
         if (r <= 1) begin
            start_cmd(SD_APP_OP, acmd_arg);
            return;
         end
      end
      acmd_pend = 1'b0;
      case (ph)
         PH_CMD0: begin
            if (r == 1) begin
               init_tmr = c_init_to;
               ph = PH_CMD8;
               start_cmd(SD_SEND_IF, 32'h0000_01AA);
            end else if (retries > 1) begin
               retries--;
               start_cmd(SD_GO_IDLE, 32'd0);
            end else begin
               new_kind = 4'd0;
               finish_init();
            end
         end
         PH_CMD8: begin
            if (r == 1) begin
               read_four(PH_R7);
            end else begin
               ph = PH_PROBE;
               start_acmd(32'd0);
            end
         end
         PH_HCS: if (r == 0) enter_cmd58(); else hcs_iter();
         PH_CMD58: if (r == 0) read_four(PH_OCR); else enter_cmd58();
         PH_PROBE: begin
            if (r <= 1) begin
               new_kind = 4'd2;
               poll_acmd = 1'b1;
            end else begin
               new_kind = 4'd1;
               poll_acmd = 1'b0;
            end
            poll_iter();
         end
         PH_POLL: if (r != 0) poll_iter(); else enter_cmd16();
         PH_CMD16: begin
            enter_cmd16();
            if (r == 0 && ph == PH_CMD16) begin
               if (init_tmr == 0) new_kind = 4'd0;
               finish_init();
            end
         end
         PH_RDCMD: if (r == 0) token_start(); else read_finish();
         default: read_finish();
      endcase
   endfunction

   function automatic void on_rx(input logic [7:0] rx);
      logic [7:0] r;
      case (ph)
         PH_DUMMY: begin
            if (bcnt > 0) bcnt--;
            if (bcnt > 0) begin
               xfer(8'hFF, 1'b0);
            end else begin
               ph = PH_CMD0;
               retries = c_idle_retr;
               new_kind = 4'd0;
               start_cmd(SD_GO_IDLE, 32'd0);
            end
         end
         PH_R7, PH_OCR: begin
            ocr = {ocr[23:0], rx};
            bcnt++;
            if (bcnt < 4) begin
               xfer(8'hFF, 1'b1);
            end else if (ph == PH_OCR) begin
               new_kind = ocr[30] ? 4'd12 : 4'd4;
               enter_cmd16();
            end else if (ocr[15:0] == 16'h01AA) begin
               hcs_iter();
            end else begin
               new_kind = 4'd0;
               enter_cmd16();
            end
         end
         PH_INIT_END: begin
            kind = new_kind;
            not_init = (new_kind == 0);
            o_done = 1'b1;
            o_status = not_init ? STAT_NRDY : STAT_OK;
            stop_io();
            ph = PH_IDLE;
         end
         PH_TOKEN: begin
            if (rx == 8'hFF && wait_tmr != 0) begin
               xfer(8'hFF, 1'b1);
            end else if (rx == 8'hFE) begin
               ph = PH_DATA;
               bcnt = 16'd0;
               xfer(8'hFF, 1'b1);
            end else begin
               after_blocks();
            end
         end
         PH_DATA: begin
            o_data = rx;
            o_dv = 1'b1;
            bcnt++;
            if (bcnt >= BLOCK_BYTES) begin
               ph = PH_CRC;
               bcnt = 16'd0;
            end
            xfer(8'hFF, 1'b1);
         end
         PH_CRC: begin
            bcnt++;
            if (bcnt < 2) begin
               xfer(8'hFF, 1'b1);
            end else begin
               blocks_left--;
               if (blocks_left != 0) token_start();
               else after_blocks();
            end
         end
         PH_READ_END: begin
            o_done = 1'b1;
            o_status = (blocks_left != 0) ? STAT_ERR : STAT_OK;
            stop_io();
            ph = PH_IDLE;
         end
         default: if (cmd_rx(rx, r)) on_resp(r);
      endcase
   endfunction

   function automatic void start_read(input logic d, input logic [31:0] sec,
                                      input logic [15:0] cnt);
      if (d || cnt == 0) begin
         o_done = 1'b1;
         o_status = STAT_PARAM;
         return;
      end
      if (not_init) begin
         o_done = 1'b1;
         o_status = STAT_NRDY;
         return;
      end
      // Byte-addressed cards take the sector times the block size.
      addr = kind[3] ? sec : (sec << 9);
      blocks_left = cnt;
      multi = (cnt > 1);
      ph = PH_RDCMD;
      start_cmd(multi ? SD_RD_MULTI : SD_RD_SINGLE, addr);
   endfunction

   function automatic void sequencer_reset();
      c_resp_att = 8'd10;
      c_ready_to = 8'd50;
      c_init_to = 8'd100;
      c_token_to = 8'd20;
      c_idle_retr = 8'd100;
      c_dummy = 8'd100;
      ph = PH_IDLE;
      stg = ST_DESEL;
      init_tmr = '0;
      wait_tmr = '0;
      kind = '0;
      not_init = 1'b1;
      retries = '0;
      bcnt = '0;
      ocr = '0;
      addr = '0;
      blocks_left = '0;
      cur_cmd = '0;
      frame_idx = '0;
      attempts = '0;
      acmd_pend = 1'b0;
      new_kind = '0;
      poll_acmd = 1'b0;
      multi = 1'b0;
      arg = '0;
      acmd_arg = '0;
      stop_io();
   endfunction

   function automatic rsp_type sequencer_step(input req_type q);
      rsp_type y;
      o_data = 8'd0;
      o_dv = 1'b0;
      o_done = 1'b0;
      o_status = STAT_OK;
      case (q.command)
         CMD_INIT: begin
            if (ph == PH_IDLE) begin
               init_tmr = '0;
               wait_tmr = '0;
               ph = PH_DUMMY;
               bcnt = 16'(c_dummy) + 16'd1;
               xfer(8'hFF, 1'b0);
            end
         end
         CMD_READ: if (ph == PH_IDLE) start_read(q.drive, q.sector, q.block_count);
         CMD_RX: if (ph != PH_IDLE && txv) on_rx(q.rx_byte);
         default: begin
            if (init_tmr != 0) init_tmr--;
            if (wait_tmr != 0) wait_tmr--;
         end
      endcase
      y.tx_byte = txb;
      y.tx_valid = txv;
      y.card_selected = csel;
      y.data_byte = o_data;
      y.data_valid = o_dv;
      y.done_res = o_done;
      y.status = o_status;
      y.card_kind = kind;
      y.not_initialized = not_init;
      return y;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want_v,
                                input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0h, got %0h", name, want_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sequencer_reset();
         expected_q.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("response item with nothing expected: %p", rsp_data);
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               compare_field("tx_byte", want.tx_byte, rsp_data.tx_byte);
               compare_field("tx_valid", want.tx_valid, rsp_data.tx_valid);
               compare_field("card_selected", want.card_selected, rsp_data.card_selected);
               compare_field("data_byte", want.data_byte, rsp_data.data_byte);
               compare_field("data_valid", want.data_valid, rsp_data.data_valid);
               compare_field("done_res", want.done_res, rsp_data.done_res);
               compare_field("status", want.status, rsp_data.status);
               compare_field("card_kind", want.card_kind, rsp_data.card_kind);
               compare_field("not_initialized", want.not_initialized,
                             rsp_data.not_initialized);
            end
         end
         if (csr_write) begin
            case (csr_index)
               REG_RESP_ATT:  c_resp_att = csr_data;
               REG_READY_TO:  c_ready_to = csr_data;
               REG_INIT_TO:   c_init_to = csr_data;
               REG_TOKEN_TO:  c_token_to = csr_data;
               REG_IDLE_RETR: c_idle_retr = csr_data;
               REG_DUMMY:     c_dummy = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) expected_q.push_back(sequencer_step(req_data));
      end
      outstanding = expected_q.size();
   end

endmodule

// File: test/tb_sd_spi_init_and_block_read.sv
`timescale 1ns / 100ps
// Testbench top: SD card emulation, stimulus, idling and the final verdict.
module tb_sd_spi_init_and_block_read;
   import sdspi_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_ITEMS = 40;
   localparam int NUM_PHASES = 4;

   localparam logic [5:0] SD_GO_IDLE   = 6'd0;
   localparam logic [5:0] SD_SEND_OP   = 6'd1;
   localparam logic [5:0] SD_SEND_IF   = 6'd8;
   localparam logic [5:0] SD_STOP      = 6'd12;
   localparam logic [5:0] SD_SET_BLEN  = 6'd16;
   localparam logic [5:0] SD_RD_SINGLE = 6'd17;
   localparam logic [5:0] SD_RD_MULTI  = 6'd18;
   localparam logic [5:0] SD_APP_OP    = 6'd41;
   localparam logic [5:0] SD_APP_CMD   = 6'd55;
   localparam logic [5:0] SD_READ_OCR  = 6'd58;

   typedef enum int {
      CARD_SD2_BLOCK, CARD_SD2_BYTE, CARD_SD1, CARD_MMC, CARD_BAD_R7, CARD_SILENT
   } card_model_type;

   logic       clock, reset;
   logic       req_valid, req_stall, rsp_valid, rsp_stall;
   req_type    req_data;
   rsp_type    rsp_data;
   logic       csr_write;
   logic [2:0] csr_index;
   logic [7:0] csr_data;
   int         mismatches, outstanding;

   int             sent, got, idle_cycles, cur_idle, cur_ready;
   rsp_type        last_rsp;
   bit             quiet;
   bit             quick_reads;
   card_model_type card;
   int             polls_left, cmd0_fails, busy_left, frame_len;
   logic [7:0]     frame[6];
   bit             prev_sel;
   logic [7:0]     card_q[$];
   logic [15:0]    read_blocks;

   sd_spi_init_and_block_read dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   sd_spi_read_checker u_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .mismatches(mismatches), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         got <= got + 1;
         last_rsp <= rsp_data;
      end
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_sd_spi_init_and_block_read: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   function automatic void push_word(input logic [7:0] r1, input logic [31:0] w);
      card_q.push_back(r1);
      for (int i = 3; i >= 0; i--) card_q.push_back(w[8*i +: 8]);
   endfunction

   function automatic void push_blocks();
      int n;
      n = quick_reads ? 0 : ((read_blocks > 4) ? 1 : read_blocks);
      for (int b = 0; b < n; b++) begin
         repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2))
            card_q.push_back(8'hFF);
         card_q.push_back(8'hFE);
         repeat (BLOCK_BYTES + 2) card_q.push_back(8'($urandom));
      end
      // Long reads, and all reads once full data is no longer wanted, end on a
      // broken data token.
      if (quick_reads || read_blocks > 4) card_q.push_back(8'h0D);
   endfunction

   // Queues the card's answer to the command frame just received.
   function automatic void card_answer();
      logic [5:0] c;
      c = frame[0][5:0];
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) card_q.push_back(8'hFF);
      case (c)
         SD_GO_IDLE: if (cmd0_fails > 0) cmd0_fails--; else card_q.push_back(8'h01);
         SD_SEND_IF: begin
            if (card == CARD_SD2_BLOCK || card == CARD_SD2_BYTE) push_word(8'h01, 32'h0000_01AA);
            else if (card == CARD_BAD_R7) push_word(8'h01, 32'h0000_0155);
            else card_q.push_back(8'h05);
         end
         SD_APP_CMD: begin
            if (card == CARD_MMC) card_q.push_back(8'h05);
            else card_q.push_back((polls_left > 0) ? 8'h01 : 8'h00);
         end
         SD_APP_OP, SD_SEND_OP: begin
            if (polls_left > 0) begin
               polls_left--;
               card_q.push_back(8'h01);
            end else begin
               card_q.push_back(8'h00);
            end
         end
         SD_READ_OCR:
            push_word(8'h00, (card == CARD_SD2_BLOCK) ? 32'hC0FF_8000 : 32'h80FF_8000);
         SD_SET_BLEN: card_q.push_back(8'h00);
         SD_RD_SINGLE, SD_RD_MULTI: begin
            if ($urandom_range(0, 24) == 0) begin
               card_q.push_back(8'h04);
            end else begin
               card_q.push_back(8'h00);
               push_blocks();
            end
         end
         SD_STOP: begin
            card_q.push_back(8'($urandom));
            card_q.push_back(8'h00);
         end
         default: card_q.push_back(8'h04);
      endcase
      if ($urandom_range(0, 49) == 0) card_q.push_front(8'($urandom));
   endfunction

   // Byte the card returns for one exchange in which the host sent tx.
   function automatic logic [7:0] card_reply(input logic [7:0] tx, input logic sel);
      if (!sel) begin
         prev_sel = 1'b0;
         return 8'hFF;
      end
      if (!prev_sel) begin
         prev_sel = 1'b1;
         if (card == CARD_SILENT) busy_left = 1 << 30;
         else busy_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
      end
      if (frame_len > 0) begin
         frame[frame_len] = tx;
         frame_len++;
         if (frame_len == 6) begin
            frame_len = 0;
            card_answer();
         end
         return 8'hFF;
      end
      if (tx[7:6] == 2'b01) begin
         card_q.delete();
         frame[0] = tx;
         frame_len = 1;
         return 8'hFF;
      end
      if (card_q.size() > 0) return card_q.pop_front();
      if (busy_left > 0) begin
         busy_left--;
         return 8'h00;
      end
      return 8'hFF;
   endfunction

   task automatic push_item(input req_type it);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   // Pauses the request side until every result sent so far has come back.
   task automatic await_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (got != sent);
   endtask

   task automatic run_op(input logic [1:0] op, input card_model_type model, input logic d,
                         input logic [31:0] sec, input logic [15:0] cnt);
      req_type it;
      int      r;
      if (op == CMD_INIT) begin
         card = model;
         polls_left = $urandom_range(0, 4);
         cmd0_fails = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
         frame_len = 0;
         card_q.delete();
      end
      read_blocks = cnt;
      it.command = op;
      it.rx_byte = 8'($urandom);
      it.drive = d;
      it.sector = sec;
      it.block_count = cnt;
      push_item(it);
      await_results();
      while (!last_rsp.done_res) begin
         r = $urandom_range(0, 99);
         it.rx_byte = 8'($urandom);
         it.drive = 1'($urandom);
         it.sector = $urandom;
         it.block_count = 16'($urandom);
         if (r < ((card == CARD_SILENT) ? 50 : 10) || !last_rsp.tx_valid) begin
            it.command = CMD_TICK;
            repeat ($urandom_range(1, 4)) push_item(it);
         end else if (r < 12) begin
            // Start requests while busy are dropped by the block.
            it.command = $urandom_range(0, 1) ? CMD_INIT : CMD_READ;
            push_item(it);
         end else if (r == 12) begin
            it.command = CMD_RX;
            push_item(it);
         end else begin
            it.command = CMD_RX;
            it.rx_byte = card_reply(last_rsp.tx_byte, last_rsp.card_selected);
            push_item(it);
         end
         await_results();
      end
   endtask

   task automatic idle_noise(input logic [7:0] rx);
      req_type it;
      it = '0;
      it.command = CMD_RX;
      it.rx_byte = rx;
      push_item(it);
      it.command = CMD_TICK;
      push_item(it);
      await_results();
   endtask

   task automatic random_op();
      int             r;
      logic [15:0]    cnt;
      card_model_type m;
      r = $urandom_range(0, 99);
      if (r < 35) begin
         m = card_model_type'($urandom_range(0, 4));
         if (cur_idle * cur_ready <= 64 && $urandom_range(0, 5) == 0) m = CARD_SILENT;
         run_op(CMD_INIT, m, 1'($urandom), $urandom, 16'($urandom));
      end else if (r < 40) begin
         idle_noise(8'($urandom));
      end else begin
         r = $urandom_range(0, 99);
         if (r < 70) cnt = 16'd1;
         else if (r < 88) cnt = 16'($urandom_range(2, 3));
         else if (r < 95) cnt = 16'($urandom_range(4, 65535));
         else cnt = 16'd0;
         run_op(CMD_READ, card, ($urandom_range(0, 19) == 0), $urandom, cnt);
      end
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [7:0] v);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
   endtask

   task automatic configure(input int p);
      logic [7:0] v[6];
      for (int i = 0; i < 6; i++) begin
         if (p == 1) v[i] = 8'd1;
         else if (p == 2) v[i] = 8'd255;
         else v[i] = 8'($urandom_range(1, 255));
      end
      if (v[5] < 10) v[5] = 8'd10;
      if (p >= 3) begin
         v[4] = 8'($urandom_range(1, 6));
         v[1] = 8'($urandom_range(1, 20));
      end
      await_results();
      repeat (4) @(posedge clock);
      write_reg(REG_RESP_ATT, v[0]);
      write_reg(REG_READY_TO, v[1]);
      write_reg(REG_INIT_TO, v[2]);
      write_reg(REG_TOKEN_TO, v[3]);
      write_reg(REG_IDLE_RETR, v[4]);
      write_reg(REG_DUMMY, v[5]);
      csr_write <= 1'b0;
      cur_ready = v[1];
      cur_idle = v[4];
   endtask

   initial begin
      int start;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = REG_RESP_ATT;
      csr_data = 8'd0;
      quiet = 1'b0;
      quick_reads = 1'b0;
      sent = 0;
      got = 0;
      last_rsp = '0;
      card = CARD_SD2_BLOCK;
      cur_idle = 100;
      cur_ready = 50;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part: reads before init, bad parameters, each card family.
      run_op(CMD_READ, card, 1'b0, 32'hFFFF_FFFF, 16'hFFFF);
      run_op(CMD_READ, card, 1'b1, 32'd0, 16'd5);
      run_op(CMD_READ, card, 1'b0, 32'h1234_5678, 16'd0);
      idle_noise(8'h00);
      idle_noise(8'hFF);
      // Short dummy clocking keeps each init item count small.
      write_reg(REG_DUMMY, 8'd10);
      csr_write <= 1'b0;
      run_op(CMD_INIT, CARD_SD2_BLOCK, 1'b1, 32'd0, 16'd0);
      run_op(CMD_READ, card, 1'b0, 32'hFFFF_FFFF, 16'd1);
      // From here on the card breaks each read at its first data token.
      quick_reads = 1'b1;
      run_op(CMD_READ, card, 1'b0, 32'd0, 16'd3);
      run_op(CMD_INIT, CARD_SD2_BYTE, 1'b0, 32'd0, 16'd0);
      run_op(CMD_READ, card, 1'b0, 32'h00FF_FFFF, 16'd2);
      run_op(CMD_INIT, CARD_SD1, 1'b0, 32'd0, 16'd0);
      run_op(CMD_READ, card, 1'b0, 32'h0000_0001, 16'd1);
      run_op(CMD_INIT, CARD_MMC, 1'b0, 32'd0, 16'd0);
      run_op(CMD_READ, card, 1'b0, 32'h8000_0000, 16'hFFFF);
      run_op(CMD_INIT, CARD_BAD_R7, 1'b0, 32'd0, 16'd0);
      run_op(CMD_READ, card, 1'b0, 32'd7, 16'd1);

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) configure(p);
         quiet = (p == NUM_PHASES - 1);
         start = sent;
         while (sent - start < PHASE_ITEMS) random_op();
      end

      await_results();
      repeat (10) @(posedge clock);
      if (outstanding != 0) $error("%0d expected response items never arrived", outstanding);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb_sd_spi_init_and_block_read: done, clean");
      end else begin
         $display("tb_sd_spi_init_and_block_read: done, errors");
      end
      $finish;
   end

endmodule
